>>> hw/rtl/ikf_pkg.sv
// ----------------------------------------------------------------------------
// IMU position fusion package
// Widths, codes, handshake structs and saturating helpers shared by the
// fusion block and its bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package ikf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DT_W      = 16;
	localparam int W         = 32;
	localparam int NUM_AXES  = 3;
	localparam int AX_W      = 2;

	// Multiplicand covers 4*v + rnd(s*dt) and a + prev, multiplier covers dt and the gain.
	localparam int MA_W  = 35;
	localparam int Q_W   = FRAC_BITS + 1;
	localparam int MB_W  = (Q_W > DT_W + 1) ? Q_W : DT_W + 1;
	localparam int P_W   = MA_W + MB_W;
	localparam int CNT_W = $clog2(MB_W + 1);
	localparam int DEN_W = W + 1;
	localparam int REM_W = W + 2;

	localparam logic [Q_W-1:0]  ONE           = Q_W'(1) << FRAC_BITS;
	localparam logic [DT_W-1:0] STEP_TIME_RST = 16'd6554;
	localparam logic [W-1:0]    MIN_INT_RST   = 32'd100000;

	typedef enum logic [0:0] {
		REG_STEP_TIME    = 1'b0,
		REG_MIN_INTERVAL = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		FUNC_ACCEL = 1'b0,
		FUNC_FIX   = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_A_L1,
		ST_A_W1,
		ST_A_L2,
		ST_A_W2,
		ST_F_LD,
		ST_F_WD,
		ST_F_L1,
		ST_F_W1,
		ST_F_L2,
		ST_F_W2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	typedef struct packed {
		logic                   start;
		logic signed [MA_W-1:0] a;
		logic [MB_W-1:0]        b;
	} mul_req_t;

	typedef struct packed {
		logic         start;
		logic [W-1:0] pp;
		logic [W-1:0] q;
	} div_req_t;

	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	function automatic logic signed [W-1:0] sat_s(input logic signed [63:0] x);
		logic signed [W-1:0] r;
		if (x > SMAX)
			r = SMAX[W-1:0];
		else if (x < SMIN)
			r = SMIN[W-1:0];
		else
			r = x[W-1:0];
		return r;
	endfunction

	function automatic logic [W-1:0] sat_u(input logic [63:0] x);
		return (x > 64'hFFFF_FFFF) ? '1 : x[W-1:0];
	endfunction

	// Round half up, then shift right arithmetically.
	function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

endpackage

>>> hw/rtl/ikf_if.sv
// ----------------------------------------------------------------------------
// IMU position fusion channels
// Valid/ready channels for measurement items and fused estimates.
// ----------------------------------------------------------------------------
interface ikf_meas_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic signed [ikf_pkg::W-1:0] val_x;
	logic signed [ikf_pkg::W-1:0] val_y;
	logic signed [ikf_pkg::W-1:0] val_z;
	logic [ikf_pkg::W-1:0]        var_x;
	logic [ikf_pkg::W-1:0]        var_y;
	logic [ikf_pkg::W-1:0]        var_z;
	logic [ikf_pkg::W-1:0]        stamp;

	modport source(output valid, func, val_x, val_y, val_z, var_x, var_y, var_z, stamp,
		input ready);
	modport sink(input valid, func, val_x, val_y, val_z, var_x, var_y, var_z, stamp,
		output ready);
endinterface

interface ikf_fused_if;
	logic                         valid;
	logic                         ready;
	logic signed [ikf_pkg::W-1:0] est_x;
	logic signed [ikf_pkg::W-1:0] est_y;
	logic signed [ikf_pkg::W-1:0] est_z;
	logic                         changed;

	modport source(output valid, est_x, est_y, est_z, changed, input ready);
	modport sink(input valid, est_x, est_y, est_z, changed, output ready);
endinterface

>>> hw/rtl/ikf_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module ikf_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ikf_pkg::mul_req_t                   req,
	output ikf_pkg::unit_sts_t                  sts,
	output logic signed [ikf_pkg::P_W-1:0]      prod
);

	logic signed [ikf_pkg::MA_W-1:0] a_q;
	logic [ikf_pkg::MB_W-1:0]        b_q;
	logic signed [ikf_pkg::P_W-1:0]  acc_q;
	logic [ikf_pkg::CNT_W-1:0]       cnt_q;
	logic                            busy_q;
	logic                            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ikf_pkg::CNT_W'(ikf_pkg::MB_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ikf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< 1) + (b_q[ikf_pkg::MB_W-1] ? ikf_pkg::P_W'(a_q) : '0);
			b_q   <= b_q << 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = acc_q;

endmodule

>>> hw/rtl/ikf_div.sv
// ----------------------------------------------------------------------------
// Bit-serial gain divider
// Computes floor(pp * 2^FRAC_BITS / (pp + q)) by restoring division, one
// quotient bit per cycle. A zero denominator gives a zero gain.
// ----------------------------------------------------------------------------
module ikf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ikf_pkg::div_req_t           req,
	output ikf_pkg::unit_sts_t          sts,
	output logic [ikf_pkg::Q_W-1:0]     quot
);

	logic [ikf_pkg::DEN_W-1:0] den_q;
	logic [ikf_pkg::REM_W-1:0] rem_q;
	logic [ikf_pkg::Q_W-1:0]   q_q;
	logic                      lsb_q;
	logic [ikf_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [ikf_pkg::REM_W-1:0] sh;
	logic                      ge;

	// The quotient is below 2^(FRAC_BITS+1), so the remainder starts at pp/2
	// and only the low dividend bits are shifted in: pp[0], then zeros.
	always_comb begin
		sh = {rem_q[ikf_pkg::REM_W-2:0],
			(cnt_q == ikf_pkg::CNT_W'(ikf_pkg::Q_W)) ? lsb_q : 1'b0};
		ge = sh >= ikf_pkg::REM_W'(den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ikf_pkg::CNT_W'(ikf_pkg::Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ikf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= ikf_pkg::DEN_W'(req.pp) + ikf_pkg::DEN_W'(req.q);
			rem_q <= ikf_pkg::REM_W'(req.pp >> 1);
			lsb_q <= req.pp[0];
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? sh - ikf_pkg::REM_W'(den_q) : sh;
			q_q   <= {q_q[ikf_pkg::Q_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = (den_q == '0) ? '0 : q_q;

endmodule

>>> hw/rtl/imu_position_kalman_fusion.sv
// ----------------------------------------------------------------------------
// IMU position Kalman fusion
// Per-axis scalar Kalman filter: accelerometer dead reckoning corrected by
// position fixes, Q16.16 fixed point with saturation.
// ----------------------------------------------------------------------------
// Usage: items arrive on the meas channel (func 0 accelerometer sample,
// func 1 position fix) and each item yields exactly one transfer on the fused
// channel carrying the three estimates and a changed flag. The block takes one
// item at a time; meas.ready is high only while the sequencer is idle.
// Sequencing: a skipped item (first sample, first fix, or a sample that comes
// too early) goes straight to the output stage. An applied accelerometer
// sample uses the bit-serial multiplier twice per axis, and an applied fix
// uses the bit-serial divider once and the multiplier twice per axis, for the
// three axes in turn. Items are accepted in the cycle after the previous
// result is loaded into the output register.
// Reset clears the estimates, variances, velocities and start flags, and loads
// step_time with 6554 and min_interval with 100000. Configuration writes are
// taken at any edge with cfg_we high and must only happen while idle.
// If the receiver stalls, the result waits in the output register; one more
// item may be computed meanwhile and then holds until the register frees up.
// ----------------------------------------------------------------------------
module imu_position_kalman_fusion (
	input  logic                        clk,
	input  logic                        arst_n,
	ikf_meas_if.sink                    meas,
	ikf_fused_if.source                 fused,
	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [ikf_pkg::W-1:0]       cfg_data
);

	localparam int W  = ikf_pkg::W;
	localparam int NA = ikf_pkg::NUM_AXES;

	ikf_pkg::state_t state_q, state_nxt;

	logic [ikf_pkg::DT_W-1:0] step_time_q;
	logic [W-1:0]             min_int_q;

	logic                      accel_started_q;
	logic                      fix_started_q;
	logic [W-1:0]              last_time_q;
	logic signed [W-1:0]       prev_q       [NA];
	logic signed [W-1:0]       vel_q        [NA];
	logic signed [W-1:0]       est_q        [NA];
	logic signed [W-1:0]       prior_est_q  [NA];
	logic [W-1:0]              var_q        [NA];
	logic [W-1:0]              prior_var_q  [NA];

	logic                      func_q;
	logic signed [W-1:0]       val_in_q     [NA];
	logic [W-1:0]              var_in_q     [NA];
	logic [W-1:0]              stamp_q;

	logic [ikf_pkg::AX_W-1:0]        axis_q;
	logic signed [W+2:0]             r17_q;
	logic signed [ikf_pkg::MA_W-1:0] m_q;
	logic [ikf_pkg::Q_W-1:0]         k_q;
	logic                            changed_q;

	logic                      out_valid_q;
	logic signed [W-1:0]       out_est_q    [NA];
	logic                      out_changed_q;

	ikf_pkg::mul_req_t               mul_req;
	ikf_pkg::unit_sts_t              mul_sts;
	logic signed [ikf_pkg::P_W-1:0]  mul_prod;
	ikf_pkg::div_req_t               div_req;
	ikf_pkg::unit_sts_t              div_sts;
	logic [ikf_pkg::Q_W-1:0]         div_quot;

	logic                      take;
	logic                      early;
	logic                      last_axis;
	logic                      out_load;
	logic signed [63:0]        prod64;
	logic signed [63:0]        r16;
	logic signed [63:0]        r17;
	logic signed [63:0]        d;

	ikf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	ikf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts),
		.quot   (div_quot)
	);

	assign take      = meas.valid && meas.ready;
	assign early     = (stamp_q - last_time_q) <= min_int_q;
	assign last_axis = axis_q == ikf_pkg::AX_W'(NA - 1);
	assign out_load  = (state_q == ikf_pkg::ST_OUT) && (!out_valid_q || fused.ready);
	assign prod64    = 64'(mul_prod);
	assign r16       = ikf_pkg::rnd(prod64, ikf_pkg::DT_W);
	assign r17       = ikf_pkg::rnd(prod64, ikf_pkg::DT_W + 1);
	assign d         = ikf_pkg::rnd(prod64, ikf_pkg::DT_W + 2);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ikf_pkg::ST_IDLE:   if (meas.valid) state_nxt = ikf_pkg::ST_DECIDE;
			ikf_pkg::ST_DECIDE: begin
				if (func_q == ikf_pkg::FUNC_ACCEL) begin
					state_nxt = (!accel_started_q || early) ? ikf_pkg::ST_OUT : ikf_pkg::ST_A_L1;
				end else begin
					state_nxt = !fix_started_q ? ikf_pkg::ST_OUT : ikf_pkg::ST_F_LD;
				end
			end
			ikf_pkg::ST_A_L1:   state_nxt = ikf_pkg::ST_A_W1;
			ikf_pkg::ST_A_W1:   if (mul_sts.done) state_nxt = ikf_pkg::ST_A_L2;
			ikf_pkg::ST_A_L2:   state_nxt = ikf_pkg::ST_A_W2;
			ikf_pkg::ST_A_W2:   if (mul_sts.done)
				state_nxt = last_axis ? ikf_pkg::ST_OUT : ikf_pkg::ST_A_L1;
			ikf_pkg::ST_F_LD:   state_nxt = ikf_pkg::ST_F_WD;
			ikf_pkg::ST_F_WD:   if (div_sts.done) state_nxt = ikf_pkg::ST_F_L1;
			ikf_pkg::ST_F_L1:   state_nxt = ikf_pkg::ST_F_W1;
			ikf_pkg::ST_F_W1:   if (mul_sts.done) state_nxt = ikf_pkg::ST_F_L2;
			ikf_pkg::ST_F_L2:   state_nxt = ikf_pkg::ST_F_W2;
			ikf_pkg::ST_F_W2:   if (mul_sts.done)
				state_nxt = last_axis ? ikf_pkg::ST_OUT : ikf_pkg::ST_F_LD;
			ikf_pkg::ST_OUT:    if (out_load) state_nxt = ikf_pkg::ST_IDLE;
			default:            state_nxt = ikf_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		meas.ready    = 1'b0;
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		div_req.start = 1'b0;
		div_req.pp    = prior_var_q[axis_q];
		div_req.q     = var_in_q[axis_q];
		unique case (state_q)
			ikf_pkg::ST_IDLE: meas.ready = 1'b1;
			ikf_pkg::ST_A_L1: begin
				mul_req.start = 1'b1;
				mul_req.a     = ikf_pkg::MA_W'(64'(val_in_q[axis_q]) + 64'(prev_q[axis_q]));
				mul_req.b     = ikf_pkg::MB_W'(step_time_q);
			end
			ikf_pkg::ST_A_L2: begin
				mul_req.start = 1'b1;
				mul_req.a     = m_q;
				mul_req.b     = ikf_pkg::MB_W'(step_time_q);
			end
			ikf_pkg::ST_F_LD: div_req.start = 1'b1;
			ikf_pkg::ST_F_L1: begin
				mul_req.start = 1'b1;
				mul_req.a     = ikf_pkg::MA_W'(64'(val_in_q[axis_q]) - 64'(prior_est_q[axis_q]));
				mul_req.b     = ikf_pkg::MB_W'(k_q);
			end
			ikf_pkg::ST_F_L2: begin
				mul_req.start = 1'b1;
				mul_req.a     = ikf_pkg::MA_W'({1'b0, prior_var_q[axis_q]});
				mul_req.b     = ikf_pkg::MB_W'(ikf_pkg::ONE - k_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ikf_pkg::ST_IDLE;
			step_time_q <= ikf_pkg::STEP_TIME_RST;
			min_int_q   <= ikf_pkg::MIN_INT_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				unique case (cfg_idx)
					ikf_pkg::REG_STEP_TIME:    step_time_q <= cfg_data[ikf_pkg::DT_W-1:0];
					ikf_pkg::REG_MIN_INTERVAL: min_int_q   <= cfg_data;
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (fused.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_started_q <= 1'b0;
			fix_started_q   <= 1'b0;
			last_time_q     <= '0;
			axis_q          <= '0;
			changed_q       <= 1'b0;
			for (int i = 0; i < NA; i++) begin
				prev_q[i]      <= '0;
				vel_q[i]       <= '0;
				est_q[i]       <= '0;
				prior_est_q[i] <= '0;
				var_q[i]       <= '0;
				prior_var_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ikf_pkg::ST_DECIDE: begin
					axis_q    <= '0;
					changed_q <= 1'b0;
					if (func_q == ikf_pkg::FUNC_ACCEL) begin
						if (!accel_started_q) begin
							accel_started_q <= 1'b1;
							last_time_q     <= stamp_q;
							for (int i = 0; i < NA; i++) begin
								prev_q[i] <= val_in_q[i];
								vel_q[i]  <= '0;
							end
						end
					end else begin
						fix_started_q <= 1'b1;
					end
				end
				ikf_pkg::ST_A_W2: if (mul_sts.done) begin
					vel_q[axis_q]       <= ikf_pkg::sat_s(64'(vel_q[axis_q]) + 64'(r17_q));
					est_q[axis_q]       <= ikf_pkg::sat_s(64'(est_q[axis_q]) + d);
					prior_est_q[axis_q] <= ikf_pkg::sat_s(64'(est_q[axis_q]) + d);
					var_q[axis_q]       <= ikf_pkg::sat_u(64'(var_q[axis_q]) + 64'(var_in_q[axis_q]));
					prior_var_q[axis_q] <= ikf_pkg::sat_u(64'(var_q[axis_q]) + 64'(var_in_q[axis_q]));
					prev_q[axis_q]      <= val_in_q[axis_q];
					if (last_axis) begin
						last_time_q <= stamp_q;
						changed_q   <= 1'b1;
						axis_q      <= '0;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				ikf_pkg::ST_F_W1: if (mul_sts.done) begin
					est_q[axis_q] <= ikf_pkg::sat_s(64'(prior_est_q[axis_q]) +
						ikf_pkg::rnd(prod64, ikf_pkg::FRAC_BITS));
				end
				ikf_pkg::ST_F_W2: if (mul_sts.done) begin
					var_q[axis_q] <= ikf_pkg::sat_u(
						unsigned'(ikf_pkg::rnd(prod64, ikf_pkg::FRAC_BITS)));
					if (last_axis) begin
						changed_q <= 1'b1;
						axis_q    <= '0;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Item capture, intermediate products and output register
	always_ff @(posedge clk) begin
		if (take) begin
			func_q      <= meas.func;
			val_in_q[0] <= meas.val_x;
			val_in_q[1] <= meas.val_y;
			val_in_q[2] <= meas.val_z;
			var_in_q[0] <= meas.var_x;
			var_in_q[1] <= meas.var_y;
			var_in_q[2] <= meas.var_z;
			stamp_q     <= meas.stamp;
		end
		if (state_q == ikf_pkg::ST_A_W1 && mul_sts.done) begin
			r17_q <= r17[W+2:0];
			m_q   <= ikf_pkg::MA_W'((64'(vel_q[axis_q]) <<< 2) + r16);
		end
		if (state_q == ikf_pkg::ST_F_WD && div_sts.done)
			k_q <= div_quot;
		if (out_load) begin
			for (int i = 0; i < NA; i++)
				out_est_q[i] <= est_q[i];
			out_changed_q <= changed_q;
		end
	end

	assign fused.valid   = out_valid_q;
	assign fused.est_x   = out_est_q[0];
	assign fused.est_y   = out_est_q[1];
	assign fused.est_z   = out_est_q[2];
	assign fused.changed = out_changed_q;

`ifndef NO_ASSERTIONS
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q != 2'd3)
		else $error("axis counter out of range");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ikf_pkg::ST_F_L1) |-> (k_q <= ikf_pkg::ONE))
		else $error("gain above one");

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_sts.busy)
		else $error("multiplier started while busy");

	a_fix_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ikf_pkg::ST_OUT && changed_q && func_q == ikf_pkg::FUNC_FIX)
		|-> fix_started_q)
		else $error("fix applied before fixes started");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !fused.ready && state_q == ikf_pkg::ST_OUT) |=>
		(state_q == ikf_pkg::ST_OUT || out_valid_q))
		else $error("result lost while receiver stalled");
`endif

endmodule

>>> tb/sv/tb_ikf_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The fusion channels are declared next to the RTL; this file holds the item
// records that the testbench uses on the measurement and fused sides.
// ----------------------------------------------------------------------------
package tb_ikf_pkg;

	typedef struct {
		ikf_pkg::func_t     func;
		logic signed [31:0] val [3];
		logic [31:0]        var_ [3];
		logic [31:0]        stamp;
		logic               is_cfg;
		ikf_pkg::reg_idx_t  cfg_idx;
		logic [31:0]        cfg_data;
	} meas_item_t;

	typedef struct {
		logic signed [31:0] est [3];
		logic               changed;
	} fused_item_t;
endpackage

>>> tb/sv/tb_imu_position_kalman_fusion.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU position Kalman fusion testbench
// Drives directed and random accelerometer samples and position fixes with
// random idling on both channels, predicts each fused estimate with a
// bit-accurate model of the per-axis filter and checks every transfer.
// ----------------------------------------------------------------------------
module tb_imu_position_kalman_fusion;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_idx = 0;
	logic [31:0] cfg_data = 0;

	ikf_meas_if  meas ();
	ikf_fused_if fused ();

	imu_position_kalman_fusion u_dut (
		.clk(clk), .arst_n(arst_n), .meas(meas.sink), .fused(fused.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Filter state mirrored by the predictor.
	logic [15:0]        m_step;
	logic [31:0]        m_min_int;
	logic               m_accel_on, m_fix_on;
	logic [31:0]        m_last_t;
	logic signed [31:0] m_prev_a [3], m_vel [3], m_est [3], m_prior_est [3];
	logic [31:0]        m_var [3], m_prior_var [3];

	tb_ikf_pkg::meas_item_t  pending_items [$];
	tb_ikf_pkg::fused_item_t expected_fused [$];
	int          send_idle_pct = 9, recv_idle_pct = 55;
	int          hold_off = 0;
	int          errors = 0;
	int          cycles = 0;
	logic        stim_done = 0;
	// High while the head item is offered and its transfer has not happened yet.
	logic        in_busy = 0;

	function automatic longint rnd_shift(longint x, int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [31:0] clamp_s(longint x);
		if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic [31:0] clamp_u(longint x);
		return (x > 64'sd4294967295) ? 32'hFFFFFFFF : x[31:0];
	endfunction

	task automatic reset_filter();
		m_step = 16'd6554;
		m_min_int = 32'd100000;
		m_accel_on = 0;
		m_fix_on = 0;
		m_last_t = 0;
		for (int i = 0; i < 3; i++) begin
			m_prev_a[i] = 0; m_vel[i] = 0; m_est[i] = 0;
			m_prior_est[i] = 0; m_var[i] = 0; m_prior_var[i] = 0;
		end
	endtask

	task automatic fuse_item(input tb_ikf_pkg::meas_item_t it);
		tb_ikf_pkg::fused_item_t r;
		longint      s, sdt, dt, vold, d, pp, den, k, innov;
		logic [31:0] gap;
		r.changed = 0;
		dt = m_step;
		if (it.func == ikf_pkg::FUNC_ACCEL) begin
			gap = it.stamp - m_last_t;
			if (!m_accel_on) begin
				m_accel_on = 1;
				for (int i = 0; i < 3; i++) begin
					m_prev_a[i] = it.val[i];
					m_vel[i] = 0;
				end
				m_last_t = it.stamp;
			end else if (gap > m_min_int) begin
				for (int i = 0; i < 3; i++) begin
					s = longint'(it.val[i]) + longint'(m_prev_a[i]);
					sdt = s * dt;
					vold = m_vel[i];
					d = rnd_shift(4 * vold * dt + rnd_shift(sdt, 16) * dt, 18);
					m_vel[i] = clamp_s(vold + rnd_shift(sdt, 17));
					m_prior_est[i] = clamp_s(longint'(m_est[i]) + d);
					m_prior_var[i] = clamp_u(longint'(m_var[i]) + longint'(it.var_[i]));
					m_est[i] = m_prior_est[i];
					m_var[i] = m_prior_var[i];
					m_prev_a[i] = it.val[i];
				end
				m_last_t = it.stamp;
				r.changed = 1;
			end
		end else if (!m_fix_on) begin
			m_fix_on = 1;
		end else begin
			for (int i = 0; i < 3; i++) begin
				pp = m_prior_var[i];
				den = pp + longint'(it.var_[i]);
				k = (den != 0) ? (pp <<< 16) / den : 0;
				if (k > 65536) k = 65536;
				innov = longint'(it.val[i]) - longint'(m_prior_est[i]);
				m_est[i] = clamp_s(longint'(m_prior_est[i]) + rnd_shift(k * innov, 16));
				m_var[i] = clamp_u(rnd_shift((65536 - k) * pp, 16));
			end
			r.changed = 1;
		end
		for (int i = 0; i < 3; i++) r.est[i] = m_est[i];
		expected_fused.push_back(r);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'hFFFFFFFF;
			3: return 0;
			4: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_item(input ikf_pkg::func_t f, input logic [31:0] v,
			input logic [31:0] q, input logic [31:0] t);
		tb_ikf_pkg::meas_item_t it;
		it.is_cfg = 0;
		it.func = f;
		for (int i = 0; i < 3; i++) begin
			it.val[i] = (i == 0) ? v : rand_word();
			it.var_[i] = (i == 0) ? q : ($urandom_range(0, 3) == 0 ? rand_word()
				: $urandom_range(0, 32'h40000));
		end
		it.stamp = t;
		it.cfg_idx = ikf_pkg::REG_STEP_TIME;
		it.cfg_data = 0;
		pending_items.push_back(it);
	endtask

	task automatic add_cfg(input ikf_pkg::reg_idx_t idx, input logic [31:0] data);
		tb_ikf_pkg::meas_item_t it;
		it.is_cfg = 1;
		it.func = ikf_pkg::FUNC_ACCEL;
		for (int i = 0; i < 3; i++) begin
			it.val[i] = 0;
			it.var_[i] = 0;
		end
		it.stamp = 0;
		it.cfg_idx = idx;
		it.cfg_data = data;
		pending_items.push_back(it);
	endtask

	// Long receiver stall, counted down on its own.
	always @(posedge clk) begin
		if (hold_off > 0) hold_off <= hold_off - 1;
	end

	// Driver: a configuration entry waits until every result has come in.
	always @(negedge clk) begin
		if (arst_n) begin
			cfg_we <= 0;
			if (pending_items.size() != 0 && pending_items[0].is_cfg) begin
				meas.valid <= 0;
				if (expected_fused.size() == 0) begin
					repeat (200) @(posedge clk);
					@(negedge clk);
					cfg_we <= 1;
					cfg_idx <= pending_items[0].cfg_idx;
					cfg_data <= pending_items[0].cfg_data;
					if (pending_items[0].cfg_idx == ikf_pkg::REG_STEP_TIME)
						m_step = pending_items[0].cfg_data[15:0];
					else
						m_min_int = pending_items[0].cfg_data;
					pending_items.pop_front();
				end
			end else if (!in_busy) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_busy = 1;
					meas.valid <= 1;
					meas.func <= pending_items[0].func;
					meas.val_x <= pending_items[0].val[0];
					meas.val_y <= pending_items[0].val[1];
					meas.val_z <= pending_items[0].val[2];
					meas.var_x <= pending_items[0].var_[0];
					meas.var_y <= pending_items[0].var_[1];
					meas.var_z <= pending_items[0].var_[2];
					meas.stamp <= pending_items[0].stamp;
				end else begin
					meas.valid <= 0;
				end
			end
			if (hold_off > 0)
				fused.ready <= 0;
			else
				fused.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: predict at input transfer, check at output transfer.
	always @(posedge clk) begin
		tb_ikf_pkg::fused_item_t e;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (meas.valid && meas.ready) begin
				fuse_item(pending_items.pop_front());
				in_busy = 0;
			end
			if (fused.valid && fused.ready) begin
				if (expected_fused.size() == 0) begin
					$error("unexpected fused transfer");
					errors++;
				end else begin
					e = expected_fused.pop_front();
					if (fused.est_x !== e.est[0]) begin
						$error("est_x expected %0d actual %0d", e.est[0], fused.est_x);
						errors++;
					end
					if (fused.est_y !== e.est[1]) begin
						$error("est_y expected %0d actual %0d", e.est[1], fused.est_y);
						errors++;
					end
					if (fused.est_z !== e.est[2]) begin
						$error("est_z expected %0d actual %0d", e.est[2], fused.est_z);
						errors++;
					end
					if (fused.changed !== e.changed) begin
						$error("changed expected %0d actual %0d", e.changed, fused.changed);
						errors++;
					end
				end
			end
			if (cycles > 900000) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] t;
		reset_filter();
		meas.valid = 0; meas.func = ikf_pkg::FUNC_ACCEL; meas.stamp = 0;
		meas.val_x = 0; meas.val_y = 0; meas.val_z = 0;
		meas.var_x = 0; meas.var_y = 0; meas.var_z = 0;
		fused.ready = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: first fix dropped, first sample, too early, exact limit,
		// extremes, repeated fixes.
		add_item(ikf_pkg::FUNC_FIX, 32'h00010000, 0, 0);
		add_item(ikf_pkg::FUNC_ACCEL, 32'h7FFFFFFF, 0, 32'd1000);
		add_item(ikf_pkg::FUNC_ACCEL, 32'h00010000, 5, 32'd2000);
		add_item(ikf_pkg::FUNC_ACCEL, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'd101000);
		add_item(ikf_pkg::FUNC_ACCEL, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'd201001);
		add_item(ikf_pkg::FUNC_FIX, 32'h80000000, 0, 0);
		add_item(ikf_pkg::FUNC_FIX, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_item(ikf_pkg::FUNC_ACCEL, 32'h80000000, 0, 32'hFFFFFFFF);
		add_item(ikf_pkg::FUNC_ACCEL, 32'h80000000, 0, 32'd200000);
		add_item(ikf_pkg::FUNC_FIX, 0, 0, 0);
		add_cfg(ikf_pkg::REG_STEP_TIME, 0);
		add_cfg(ikf_pkg::REG_MIN_INTERVAL, 0);
		add_item(ikf_pkg::FUNC_ACCEL, 32'h00050000, 32'h10000, 32'd200000);
		add_item(ikf_pkg::FUNC_ACCEL, 32'h00050000, 32'h10000, 32'd200001);
		add_item(ikf_pkg::FUNC_FIX, 32'h00020000, 32'h10000, 0);
		add_cfg(ikf_pkg::REG_STEP_TIME, 32'hFFFF);
		add_cfg(ikf_pkg::REG_MIN_INTERVAL, 32'hFFFFFFFF);
		add_item(ikf_pkg::FUNC_ACCEL, 32'h7FFFFFFF, 0, 32'd5);
		add_cfg(ikf_pkg::REG_MIN_INTERVAL, 32'd100);

		t = 0;
		for (int n = 0; n < 750; n++) begin
			if (n == 250) begin
				add_cfg(ikf_pkg::REG_STEP_TIME, $urandom_range(1, 65535));
				add_cfg(ikf_pkg::REG_MIN_INTERVAL, $urandom_range(0, 500));
			end
			if (n == 500) begin
				add_cfg(ikf_pkg::REG_STEP_TIME, 1);
				add_cfg(ikf_pkg::REG_MIN_INTERVAL, 32'hFFFFFFFE);
			end
			if (n == 600) begin
				add_cfg(ikf_pkg::REG_STEP_TIME, 6554);
				add_cfg(ikf_pkg::REG_MIN_INTERVAL, 50);
			end
			t = ($urandom_range(0, 19) == 0) ? $urandom : t + $urandom_range(0, 300);
			if ($urandom_range(0, 2) == 0)
				add_item(ikf_pkg::FUNC_FIX, rand_word(), $urandom_range(0, 32'h40000), t);
			else
				add_item(ikf_pkg::FUNC_ACCEL, $urandom_range(0, 32'h3FFFF) - 32'h20000,
					$urandom_range(0, 32'h8000), t);
		end

		wait (pending_items.size() < 500);
		@(negedge clk);
		hold_off = 3000;
		wait (pending_items.size() < 250);
		send_idle_pct = 55;
		recv_idle_pct = 9;
		wait (pending_items.size() < 100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait (pending_items.size() == 0 && expected_fused.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_fused.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
